>>> rtl/ir90_pkg.sv
// Shared types and constants for the 90-degree image rotation unit.
package ir90_pkg;

	localparam int PIX_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int BPP_W      = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd2;

	localparam logic [CFG_DATA_W-1:0] DIM_RESET = 9'd256;
	localparam logic [BPP_W-1:0]      BPP_RESET = 3'd3;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             eor;
		logic             eof;
	} rot_item_t;

endpackage

>>> rtl/image_rotate_90_unit.sv
// Streaming 90-degree image rotation with a ping-pong frame store.
//
// Source pixels enter on s_tdata in raster order of a frame_width by
// frame_height frame and are written into the current bank of the store.
// Every accepted item also reads one pixel of the previous complete frame
// in rotated order: output row i is source column width-1-i, top to bottom.
// Results leave on m_tdata; m_tlast marks the end of an output row and
// m_tuser the end of the output frame. The first frame after reset or after
// a register write gives no output; each later item gives exactly one.
// Throughput is one item per clock while s_tready is high: the store has one
// write and one read port and the two touch different banks. On the way to
// m_tvalid a result passes the store read register, then the output queue.
// When the receiver stalls, results collect in a two-entry output queue;
// s_tready falls only when that queue and the read stage are all full.
// Reset clears counters, bank select and the frame-ready flag and loads
// the register defaults; store contents are not cleared. Registers are
// written over the cfg channel, which is always ready, and restart the
// stream. Write them only while the block is idle.
module image_rotate_90_unit #(
	parameter int MAX_DIM    = 256,
	parameter int PIXEL_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ir90_pkg::PIX_W-1:0]     s_tdata,   // [31:0] pixel_in
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ir90_pkg::PIX_W-1:0]     m_tdata,   // [31:0] pixel_out
	output logic                           m_tlast,   // end_of_row
	output logic                           m_tuser,   // [0] end_of_frame
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ir90_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ir90_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ir90_pkg::*;

	localparam int AW  = $clog2(MAX_DIM);
	localparam int DW  = (AW + 1 > CFG_DATA_W) ? AW + 1 : CFG_DATA_W;
	localparam int MAW = 2 * AW + 1;

	function automatic logic [AW-1:0] dim_last(input logic [CFG_DATA_W-1:0] v);
		logic [DW-1:0] ve;
		ve = DW'(v);
		if (ve == '0) begin
			return '0;
		end else if (ve > DW'(MAX_DIM)) begin
			return AW'(MAX_DIM - 1);
		end else begin
			return AW'(ve - DW'(1));
		end
	endfunction

	function automatic logic [PIXEL_BITS-1:0] pix_mask(input logic [BPP_W-1:0] b);
		logic [BPP_W-1:0] n;
		logic [PIX_W-1:0] m;
		n = (b == '0) ? BPP_W'(1) : ((b > BPP_W'(4)) ? BPP_W'(4) : b);
		m = '0;
		for (int i = 0; i < 4; i++) begin
			if (BPP_W'(i) < n) begin
				m[i*8 +: 8] = 8'hFF;
			end
		end
		return PIXEL_BITS'(m);
	endfunction

	logic [AW-1:0]         w_last_q;
	logic [AW-1:0]         h_last_q;
	logic [PIXEL_BITS-1:0] mask_q;
	logic [AW-1:0]         wr_row_q;
	logic [AW-1:0]         wr_col_q;
	logic [AW-1:0]         rd_row_q;
	logic [AW-1:0]         rd_col_q;
	logic                  wbank_q;
	logic                  frame_ready_q;

	logic                  valid_s1;
	logic                  eor_s1;
	logic                  eof_s1;

	logic                  cfg_acc;
	logic                  in_acc;
	logic                  rd_en;
	logic                  q_full;
	logic                  q_valid;
	logic                  move;
	logic                  wr_col_end;
	logic                  wr_frame_end;
	logic                  eor;
	logic                  eof;
	logic [AW-1:0]         src_col;
	logic [MAW-1:0]        waddr;
	logic [MAW-1:0]        raddr;
	logic [PIXEL_BITS-1:0] wdata;
	logic [PIXEL_BITS-1:0] rdata;
	rot_item_t             item_s1;
	rot_item_t             q_item;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	assign s_tready = !(valid_s1 && q_full);
	assign in_acc   = s_tvalid && s_tready;
	assign rd_en    = in_acc && frame_ready_q;
	assign move     = valid_s1 && !q_full;

	assign wr_col_end   = (wr_col_q == w_last_q);
	assign wr_frame_end = wr_col_end && (wr_row_q == h_last_q);
	assign eor          = (rd_col_q == h_last_q);
	assign eof          = eor && (rd_row_q == w_last_q);
	assign src_col      = w_last_q - rd_row_q;

	assign waddr = {wbank_q, wr_row_q, wr_col_q};
	assign raddr = {!wbank_q, rd_col_q, src_col};
	assign wdata = s_tdata[PIXEL_BITS-1:0] & mask_q;

	ir90_store #(
		.ADDR_W (MAW),
		.DATA_W (PIXEL_BITS)
	) u_store (
		.clk   (clk),
		.we    (in_acc),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q      <= dim_last(DIM_RESET);
			h_last_q      <= dim_last(DIM_RESET);
			mask_q        <= pix_mask(BPP_RESET);
			wr_row_q      <= '0;
			wr_col_q      <= '0;
			rd_row_q      <= '0;
			rd_col_q      <= '0;
			wbank_q       <= 1'b0;
			frame_ready_q <= 1'b0;
		end else if (cfg_acc) begin
			if (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT ||
			    cfg_index == CFG_BYTES_PER_PIXEL) begin
				wr_row_q      <= '0;
				wr_col_q      <= '0;
				rd_row_q      <= '0;
				rd_col_q      <= '0;
				frame_ready_q <= 1'b0;
			end
			case (cfg_index)
				CFG_FRAME_WIDTH:     w_last_q <= dim_last(cfg_data);
				CFG_FRAME_HEIGHT:    h_last_q <= dim_last(cfg_data);
				CFG_BYTES_PER_PIXEL: mask_q   <= pix_mask(cfg_data[BPP_W-1:0]);
				default: ;
			endcase
		end else if (in_acc) begin
			if (frame_ready_q) begin
				if (eor) begin
					rd_col_q <= '0;
					rd_row_q <= eof ? '0 : rd_row_q + AW'(1);
				end else begin
					rd_col_q <= rd_col_q + AW'(1);
				end
			end
			if (wr_col_end) begin
				wr_col_q <= '0;
				if (wr_frame_end) begin
					wr_row_q      <= '0;
					wbank_q       <= !wbank_q;
					frame_ready_q <= 1'b1;
					rd_row_q      <= '0;
					rd_col_q      <= '0;
				end else begin
					wr_row_q <= wr_row_q + AW'(1);
				end
			end else begin
				wr_col_q <= wr_col_q + AW'(1);
			end
		end
	end

	// read stage: flags ride alongside the registered store output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rd_en) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			eor_s1 <= eor;
			eof_s1 <= eof;
		end
	end

	assign item_s1.pixel = PIX_W'(rdata & mask_q);
	assign item_s1.eor   = eor_s1;
	assign item_s1.eof   = eof_s1;

	ir90_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (move),
		.push_item (item_s1),
		.pop       (m_tready),
		.valid     (q_valid),
		.full      (q_full),
		.item      (q_item)
	);

	assign m_tvalid = q_valid;
	assign m_tdata  = q_item.pixel;
	assign m_tlast  = q_item.eor;
	assign m_tuser  = q_item.eof;

	a_read_launch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && frame_ready_q && !cfg_acc) |=> valid_s1)
		else $error("accepted item with a ready frame did not start a read");

	a_bank_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(wbank_q != $past(wbank_q)) |-> $past(in_acc && !cfg_acc && wr_frame_end))
		else $error("write bank changed outside a frame end");

	a_read_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_ready_q |-> (rd_row_q <= w_last_q && rd_col_q <= h_last_q))
		else $error("read counters beyond the frame");

endmodule

>>> rtl/ir90_store.sv
// Ping-pong frame store: one write port, one registered read port.
module ir90_store #(
	parameter int ADDR_W = 17,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/ir90_skid.sv
// Two-entry output queue that decouples the store read from the receiver.
module ir90_skid (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ir90_pkg::rot_item_t push_item,
	input  logic               pop,
	output logic               valid,
	output logic               full,
	output ir90_pkg::rot_item_t item
);
	import ir90_pkg::*;

	rot_item_t  item_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign valid   = (cnt_q != 2'd0);
	assign full    = (cnt_q == 2'd2);
	assign item    = item_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			item_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> bench/image_rotate_90_unit_test.sv
// Self-checking testbench for image_rotate_90_unit: frame rotation predictor and stream driver.

class rotated_pixel_tracker;
	localparam int DIM = 256;

	bit [31:0]                   frame_mem [2][DIM][DIM];
	logic [ir90_pkg::CFG_DATA_W-1:0] width_reg;
	logic [ir90_pkg::CFG_DATA_W-1:0] height_reg;
	logic [ir90_pkg::BPP_W-1:0]  bpp_reg;
	int unsigned                 wr_row, wr_col, rd_row, rd_col;
	bit                          wr_bank;
	bit                          have_frame;
	ir90_pkg::rot_item_t         rotated_due [$];
	int unsigned                 mismatches, sources_noted, results_checked, register_writes;

	function new();
		width_reg  = ir90_pkg::DIM_RESET;
		height_reg = ir90_pkg::DIM_RESET;
		bpp_reg    = ir90_pkg::BPP_RESET;
		wr_bank    = 0;
		restart();
	endfunction

	function void restart();
		wr_row     = 0;
		wr_col     = 0;
		rd_row     = 0;
		rd_col     = 0;
		have_frame = 0;
	endfunction

	// 0 behaves as 1, anything past the store size as the store size
	static function int unsigned clamp_dim(logic [ir90_pkg::CFG_DATA_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > DIM)
			return DIM;
		return v;
	endfunction

	function logic [31:0] keep_mask();
		int unsigned n;
		n = (bpp_reg == 0) ? 1 : (bpp_reg > 4) ? 4 : bpp_reg;
		if (n == 4)
			return 32'hFFFF_FFFF;
		return (32'h1 << (8 * n)) - 32'h1;
	endfunction

	function int unsigned pending();
		return rotated_due.size();
	endfunction

	function void write_register(logic [ir90_pkg::CFG_IDX_W-1:0] idx,
			logic [ir90_pkg::CFG_DATA_W-1:0] val);
		register_writes++;
		case (idx)
			ir90_pkg::CFG_FRAME_WIDTH:     width_reg = val;
			ir90_pkg::CFG_FRAME_HEIGHT:    height_reg = val;
			ir90_pkg::CFG_BYTES_PER_PIXEL: bpp_reg = val[ir90_pkg::BPP_W-1:0];
			default:                       return;
		endcase
		restart();
	endfunction

	function void note_source_pixel(logic [31:0] pix);
		int unsigned         w, h;
		logic [31:0]         keep;
		ir90_pkg::rot_item_t item;
		w    = clamp_dim(width_reg);
		h    = clamp_dim(height_reg);
		keep = keep_mask();
		sources_noted++;
		if (have_frame) begin
			item.pixel = frame_mem[!wr_bank][rd_col][w - 1 - rd_row] & keep;
			item.eor   = (rd_col + 1 >= h);
			item.eof   = item.eor && (rd_row + 1 >= w);
			rotated_due.push_back(item);
			if (item.eor) begin
				rd_col = 0;
				rd_row = item.eof ? 0 : rd_row + 1;
			end else begin
				rd_col++;
			end
		end
		frame_mem[wr_bank][wr_row][wr_col] = pix & keep;
		if (wr_col + 1 >= w) begin
			wr_col = 0;
			if (wr_row + 1 >= h) begin
				wr_row     = 0;
				wr_bank    = !wr_bank;
				have_frame = 1;
				rd_row     = 0;
				rd_col     = 0;
			end else begin
				wr_row++;
			end
		end else begin
			wr_col++;
		end
	endfunction

	task report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task check_rotated_pixel(logic [31:0] pix, logic eor, logic eof);
		ir90_pkg::rot_item_t want;
		results_checked++;
		if (rotated_due.size() == 0) begin
			report_mismatch($sformatf("result %08h with none pending", pix));
			return;
		end
		want = rotated_due.pop_front();
		if (pix !== want.pixel)
			report_mismatch($sformatf("pixel %08h, want %08h", pix, want.pixel));
		if (eor !== want.eor)
			report_mismatch($sformatf("end of row %b, want %b", eor, want.eor));
		if (eof !== want.eof)
			report_mismatch($sformatf("end of frame %b, want %b", eof, want.eof));
	endtask
endclass

module image_rotate_90_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ir90_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 270;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [PIX_W-1:0]      m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rotated_pixel_tracker sb;
	int unsigned          cycle_count;
	int unsigned          tx_idle_pct;
	int unsigned          rx_idle_pct;
	int unsigned          random_items;
	bit                   held;

	image_rotate_90_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_register(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				sb.note_source_pixel(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_rotated_pixel(m_tdata, m_tlast, m_tuser);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
			input logic [CFG_DATA_W-1:0] bpp_word);
		write_reg(CFG_FRAME_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
		write_reg(CFG_BYTES_PER_PIXEL, bpp_word);
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] pix);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and wait for every pending result, then settle
	task automatic drain(input int unsigned settle);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] next_pixel();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic stream_pixels(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_pixel(next_pixel());
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_dim();
		case ($urandom_range(9))
			0:       return '0;
			1:       return CFG_DATA_W'($urandom_range(7, 10));
			default: return CFG_DATA_W'($urandom_range(1, 6));
		endcase
	endfunction

	initial begin
		logic [PIX_W-1:0] corner_pixels [6];
		int unsigned      px, frames, total;
		bit               first_phase;

		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		cycle_count  = 0;
		tx_idle_pct  = 11;
		rx_idle_pct  = 64;
		random_items = 0;
		held         = 0;
		first_phase  = 1;
		sb           = new();
		corner_pixels = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h0000_0001, 32'hA5A5_A5A5, 32'h5A5A_5A5A};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// width and byte count stay at their reset values; height 0 acts as 1
		write_reg(CFG_FRAME_HEIGHT, 9'd0);
		stream_pixels(256 + 8);
		drain(SETTLE_CYCLES);

		// 1x1 frames: each item after the first returns the one before it
		configure(9'd1, 9'd1, 9'd4);
		foreach (corner_pixels[i])
			send_pixel(corner_pixels[i]);
		drain(SETTLE_CYCLES);
		write_reg(CFG_UNUSED, '1);
		send_pixel(32'h1234_5678);
		drain(SETTLE_CYCLES);
		// byte count 0 with upper data bits set keeps one byte
		configure(9'd3, 9'd2, 9'h1F8);
		for (int unsigned i = 0; i < 12; i++)
			send_pixel((i * 32'h0101_0101) ^ 32'hF0F0_0F0F);
		drain(SETTLE_CYCLES);

		while (random_items < RANDOM_ITEMS) begin
			drain(SETTLE_CYCLES);
			px = sb.clamp_dim(sb.width_reg) * sb.clamp_dim(sb.height_reg);
			if (!first_phase && px <= 64 && $urandom_range(4) == 0)
				write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(511)));
			else
				configure(pick_dim(), pick_dim(), CFG_DATA_W'($urandom_range(511)));
			first_phase = 0;
			px = sb.clamp_dim(sb.width_reg) * sb.clamp_dim(sb.height_reg);
			frames = (px > 64) ? 2 : $urandom_range(2, 4);
			total  = frames * px + (($urandom_range(2) == 0) ? $urandom_range(px - 1) : 0);
			for (int unsigned i = 0; i < total && random_items < RANDOM_ITEMS; i++) begin
				if (random_items < RANDOM_ITEMS / 3) begin
					tx_idle_pct = 11;
					rx_idle_pct = 64;
				end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
					tx_idle_pct = 64;
					rx_idle_pct = 11;
				end else begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
				if (!held && random_items >= RANDOM_ITEMS / 2) begin
					drain(0);
					held = 1;
				end
				send_pixel(next_pixel());
				random_items++;
			end
		end

		drain(SETTLE_CYCLES);
		$display("Sent %0d source pixels, checked %0d rotated pixels, %0d register writes.",
			sb.sources_noted, sb.results_checked, sb.register_writes);
		$display("Frames from 1x1 to 256 wide or tall, all byte counts, three stall mixes.");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

>>> files.f
rtl/ir90_pkg.sv
rtl/ir90_store.sv
rtl/ir90_skid.sv
rtl/image_rotate_90_unit.sv
bench/image_rotate_90_unit_test.sv
